@@ src/smtq_pkg.sv @@
package smtq_pkg;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_INSTALL = 2'd1;
    localparam logic [1:0] OP_KILL    = 2'd2;

    localparam logic [2:0] KIND_EXPIRED   = 3'd0;
    localparam logic [2:0] KIND_INSTALLED = 3'd1;
    localparam logic [2:0] KIND_REFUSED   = 3'd2;
    localparam logic [2:0] KIND_KILLED    = 3'd3;
    localparam logic [2:0] KIND_IGNORED   = 3'd4;
    localparam logic [2:0] KIND_TICK_DONE = 3'd5;

    localparam int IN_BITS  = 72;
    localparam int OUT_BITS = 48;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_TRD   = 9'b000000010,
        S_TPROC = 9'b000000100,
        S_TEND  = 9'b000001000,
        S_IRD   = 9'b000010000,
        S_IPROC = 9'b000100000,
        S_KRD   = 9'b001000000,
        S_KPROC = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

endpackage

@@ src/smtq_ram.sv @@
module smtq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/sorted_multi_timer_queue_unit.sv @@
// channel   direction  word fields (lsb first)
// s_axis    in         op, elapsed_ms, delay_ms, timer_slot
// m_axis    out        kind, slot_id, active_count, next_remaining_ms, has_next; tlast = last
//
// One word at a time. Tick reads each listed timer, rewrites the survivors and reports
// the expired ones. Install shifts the entries behind the new one from the list tail.
// Kill reads every entry. Refused install, ignored kill and reserved op go straight to the result word.
// Each entry visited costs one read and at most one write of the single-port-pair list memory.
// Reset clears count, busy bits and control; the list memory needs no clearing.
// A stalled output holds the sequencer; the list memory holds its contents meanwhile.
module sorted_multi_timer_queue_unit #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // op[1:0], elapsed_ms[33:2], delay_ms[65:34], timer_slot[69:66], zero pad
    input  logic [smtq_pkg::IN_BITS-1:0]  i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // kind[2:0], slot_id[6:3], active_count[11:7], next_remaining_ms[43:12],
    // has_next[44], zero pad
    output logic [smtq_pkg::OUT_BITS-1:0] o_m_axis_tdata,
    output logic                          o_m_axis_tlast
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = SW + TIME_BITS;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    smtq_pkg::t_state r_state;
    logic [CW-1:0]        r_cnt, r_lim, r_i, r_z;
    logic [SLOTS-1:0]     r_busy;
    logic                 r_pend, r_found;
    logic [TIME_BITS-1:0] r_arg, r_head;
    logic [3:0]           r_eslot;
    logic [2:0]           r_ekind;
    logic [SW-1:0]        r_nslot, r_tsi;
    logic                 r_ov, r_olast;
    logic [smtq_pkg::OUT_BITS-1:0] r_od;

    logic [1:0]  in_op;
    logic [31:0] in_el, in_dl;
    logic [3:0]  in_ts;
    logic [TIME_BITS-1:0] el_sat, dl_sat;
    logic [SW-1:0] free_slot, in_tsi;
    logic in_range, full, accept, o_free;

    logic          we, re;
    logic [SW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [SW-1:0] rd_slot;
    logic [TIME_BITS-1:0] rd_rem, sub;

    logic                 o_ld, o_last;
    logic [2:0]           o_kind;
    logic [3:0]           o_slot;
    logic [TIME_BITS-1:0] o_next;

    assign in_op = i_s_axis_tdata[1:0];
    assign in_el = i_s_axis_tdata[33:2];
    assign in_dl = i_s_axis_tdata[65:34];
    assign in_ts = i_s_axis_tdata[69:66];

    assign el_sat = ((64'(in_el) >> TIME_BITS) != 64'd0) ? TMAX : TIME_BITS'(in_el);
    assign dl_sat = ((64'(in_dl) >> TIME_BITS) != 64'd0) ? TMAX : TIME_BITS'(in_dl);
    assign in_tsi   = SW'(in_ts);
    assign in_range = 32'(in_ts) < 32'(SLOTS);
    assign full     = r_cnt >= CW'(SLOTS);

    always_comb begin
        free_slot = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_busy[k]) free_slot = SW'(k);
        end
    end

    assign o_s_axis_tready = (r_state == smtq_pkg::S_IDLE);
    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_free = !r_ov || i_m_axis_tready;

    assign rd_slot = rdata[EW-1:TIME_BITS];
    assign rd_rem  = rdata[TIME_BITS-1:0];
    assign sub     = (rd_rem > r_arg) ? rd_rem - r_arg : '0;

    smtq_ram #(.DEPTH(SLOTS), .WIDTH(EW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; raddr = '0;
        o_ld = 1'b0; o_kind = r_ekind; o_slot = r_eslot; o_last = 1'b1;
        o_next = (r_cnt != '0) ? r_head : '0;
        unique case (r_state)
            smtq_pkg::S_TRD, smtq_pkg::S_KRD: begin
                re = r_i < r_lim;
                raddr = SW'(r_i);
            end
            smtq_pkg::S_TPROC: begin
                if (!r_pend || o_free) begin
                    o_ld = r_pend;
                    o_kind = smtq_pkg::KIND_EXPIRED;
                    o_last = 1'b0;
                    o_next = sub;
                    we = (sub != '0);
                    waddr = SW'(r_i - r_z);
                    wdata = {rd_slot, sub};
                end
            end
            smtq_pkg::S_TEND: begin
                o_ld = r_pend;
                o_kind = smtq_pkg::KIND_EXPIRED;
                o_last = 1'b0;
                o_next = '0;
            end
            smtq_pkg::S_IRD: begin
                re = r_i != '0;
                raddr = SW'(r_i - CW'(1));
                we = r_i == '0;
                waddr = '0;
                wdata = {r_nslot, r_arg};
            end
            smtq_pkg::S_IPROC: begin
                we = 1'b1;
                waddr = SW'(r_i);
                wdata = (rd_rem >= r_arg) ? rdata : {r_nslot, r_arg};
            end
            smtq_pkg::S_KPROC: begin
                we = r_found;
                waddr = SW'(r_i - CW'(1));
                wdata = rdata;
            end
            smtq_pkg::S_EMIT: begin
                o_ld = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smtq_pkg::S_IDLE;
            r_cnt   <= '0;
            r_busy  <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (o_ld && o_free) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                smtq_pkg::S_IDLE: begin
                    if (accept) begin
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        if (in_op == smtq_pkg::OP_TICK) begin
                            r_state <= smtq_pkg::S_TRD;
                        end else if (in_op == smtq_pkg::OP_INSTALL) begin
                            r_state <= (dl_sat == '0 || full) ? smtq_pkg::S_EMIT
                                                              : smtq_pkg::S_IRD;
                        end else if (in_op == smtq_pkg::OP_KILL) begin
                            r_state <= (in_range && r_busy[in_tsi]) ? smtq_pkg::S_KRD
                                                                    : smtq_pkg::S_EMIT;
                        end else begin
                            r_state <= smtq_pkg::S_EMIT;
                        end
                    end
                end
                smtq_pkg::S_TRD: begin
                    r_state <= (r_i < r_lim) ? smtq_pkg::S_TPROC : smtq_pkg::S_TEND;
                end
                smtq_pkg::S_TPROC: begin
                    if (!r_pend || o_free) begin
                        if (sub == '0) begin
                            r_pend <= 1'b1;
                            r_cnt  <= r_cnt - CW'(1);
                            r_busy[rd_slot] <= 1'b0;
                        end else begin
                            r_pend <= 1'b0;
                        end
                        r_state <= smtq_pkg::S_TRD;
                    end
                end
                smtq_pkg::S_TEND: begin
                    if (!r_pend || o_free) begin
                        r_pend  <= 1'b0;
                        r_state <= smtq_pkg::S_EMIT;
                    end
                end
                smtq_pkg::S_IRD: begin
                    if (r_i == '0) begin
                        r_cnt <= r_cnt + CW'(1);
                        r_busy[r_nslot] <= 1'b1;
                        r_state <= smtq_pkg::S_EMIT;
                    end else begin
                        r_state <= smtq_pkg::S_IPROC;
                    end
                end
                smtq_pkg::S_IPROC: begin
                    if (rd_rem >= r_arg) begin
                        r_state <= smtq_pkg::S_IRD;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                        r_busy[r_nslot] <= 1'b1;
                        r_state <= smtq_pkg::S_EMIT;
                    end
                end
                smtq_pkg::S_KRD: begin
                    if (r_i < r_lim) begin
                        r_state <= smtq_pkg::S_KPROC;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                        r_busy[r_tsi] <= 1'b0;
                        r_state <= smtq_pkg::S_EMIT;
                    end
                end
                smtq_pkg::S_KPROC: begin
                    if (rd_slot == r_tsi) r_found <= 1'b1;
                    r_state <= smtq_pkg::S_KRD;
                end
                smtq_pkg::S_EMIT: begin
                    if (o_free) r_state <= smtq_pkg::S_IDLE;
                end
                default: begin
                    r_state <= smtq_pkg::S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we && waddr == '0) r_head <= wdata[TIME_BITS-1:0];
        if (o_ld && o_free) begin
            r_od <= {3'd0, (r_cnt != '0), 32'(o_next), 5'(r_cnt), o_slot, o_kind};
            r_olast <= o_last;
        end
        unique case (r_state)
            smtq_pkg::S_IDLE: begin
                r_lim <= r_cnt;
                r_z   <= '0;
                r_tsi <= in_tsi;
                r_nslot <= free_slot;
                if (in_op == smtq_pkg::OP_TICK) begin
                    r_i <= '0;
                    r_arg <= el_sat;
                    r_ekind <= smtq_pkg::KIND_TICK_DONE;
                    r_eslot <= '0;
                end else if (in_op == smtq_pkg::OP_INSTALL) begin
                    r_i <= r_cnt;
                    r_arg <= dl_sat;
                    r_ekind <= (dl_sat == '0 || full) ? smtq_pkg::KIND_REFUSED
                                                      : smtq_pkg::KIND_INSTALLED;
                    r_eslot <= (dl_sat == '0 || full) ? 4'd0 : 4'(free_slot);
                end else if (in_op == smtq_pkg::OP_KILL) begin
                    r_i <= '0;
                    r_ekind <= (in_range && r_busy[in_tsi]) ? smtq_pkg::KIND_KILLED
                                                            : smtq_pkg::KIND_IGNORED;
                    r_eslot <= in_ts;
                end else begin
                    r_i <= r_cnt;
                    r_ekind <= smtq_pkg::KIND_TICK_DONE;
                    r_eslot <= '0;
                end
            end
            smtq_pkg::S_TPROC: begin
                if (!r_pend || o_free) begin
                    r_i <= r_i + CW'(1);
                    if (sub == '0) begin
                        r_z <= r_z + CW'(1);
                        r_eslot <= 4'(rd_slot);
                    end
                end
            end
            smtq_pkg::S_TEND: begin
                if (!r_pend || o_free) r_eslot <= '0;
            end
            smtq_pkg::S_IPROC: begin
                if (rd_rem >= r_arg) r_i <= r_i - CW'(1);
            end
            smtq_pkg::S_KPROC: begin
                r_i <= r_i + CW'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_od;
    assign o_m_axis_tlast  = r_olast;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(SLOTS)) else $error("timer count above capacity");
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smtq_pkg::S_IDLE) |-> ($countones(r_busy) == 32'(r_cnt)))
        else $error("busy bits disagree with timer count");
    a_idle_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smtq_pkg::S_IDLE) |-> !r_pend) else $error("expiry left pending");
    a_waddr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (32'(waddr) < 32'(SLOTS))) else $error("list write out of range");

endmodule

@@ bench/sorted_multi_timer_queue_unit_tb.sv @@
`timescale 1ns / 100ps

module sorted_multi_timer_queue_unit_tb;

    localparam int NSLOT = 16;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot_id;
        logic [4:0]  active_count;
        logic [31:0] next_remaining_ms;
        logic        has_next;
        logic        last;
    } t_timer_word;

    class timer_queue_scoreboard;
        logic [3:0]  list_slot[NSLOT];
        logic [31:0] list_time[NSLOT];
        int          list_len;
        bit          busy[NSLOT];
        t_timer_word pending[$];
        int          errors;

        function new();
            list_len = 0;
            errors = 0;
            foreach (busy[i]) busy[i] = 0;
        endfunction

        function void push_word(logic [2:0] kind, logic [3:0] slot, bit last);
            t_timer_word w;
            w.kind = kind;
            w.slot_id = slot;
            w.active_count = list_len[4:0];
            w.next_remaining_ms = list_len != 0 ? list_time[0] : 32'd0;
            w.has_next = list_len != 0;
            w.last = last;
            pending.push_back(w);
        endfunction

        function void drop_at(int pos);
            for (int i = pos; i + 1 < list_len; i++) begin
                list_slot[i] = list_slot[i + 1];
                list_time[i] = list_time[i + 1];
            end
            list_len--;
        endfunction

        function void note_input(logic [1:0] op, logic [31:0] elapsed, logic [31:0] delay,
                                 logic [3:0] tslot);
            int s;
            int pos;
            if (op == smtq_pkg::OP_TICK) begin
                for (int i = 0; i < list_len; i++)
                    list_time[i] = list_time[i] > elapsed ? list_time[i] - elapsed : 32'd0;
                while (list_len > 0 && list_time[0] == 0) begin
                    s = list_slot[0];
                    busy[s] = 0;
                    drop_at(0);
                    push_word(smtq_pkg::KIND_EXPIRED, s[3:0], 1'b0);
                end
                push_word(smtq_pkg::KIND_TICK_DONE, 4'd0, 1'b1);
            end else if (op == smtq_pkg::OP_INSTALL) begin
                s = NSLOT;
                if (delay != 0 && list_len < NSLOT)
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (!busy[i]) s = i;
                if (s >= NSLOT) begin
                    push_word(smtq_pkg::KIND_REFUSED, 4'd0, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < list_len && list_time[pos] < delay) pos++;
                    for (int i = list_len; i > pos; i--) begin
                        list_slot[i] = list_slot[i - 1];
                        list_time[i] = list_time[i - 1];
                    end
                    list_slot[pos] = s[3:0];
                    list_time[pos] = delay;
                    list_len++;
                    busy[s] = 1;
                    push_word(smtq_pkg::KIND_INSTALLED, s[3:0], 1'b1);
                end
            end else if (op == smtq_pkg::OP_KILL) begin
                if (busy[tslot]) begin
                    for (int i = 0; i < list_len; i++)
                        if (list_slot[i] == tslot) begin
                            drop_at(i);
                            break;
                        end
                    busy[tslot] = 0;
                    push_word(smtq_pkg::KIND_KILLED, tslot, 1'b1);
                end else begin
                    push_word(smtq_pkg::KIND_IGNORED, tslot, 1'b1);
                end
            end else begin
                push_word(smtq_pkg::KIND_TICK_DONE, 4'd0, 1'b1);
            end
        endfunction

        function void check_word(t_timer_word got);
            t_timer_word want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind != want.kind)
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            if (got.slot_id != want.slot_id)
                $display("%0t: slot_id expected %0d actual %0d", $time, want.slot_id,
                         got.slot_id);
            if (got.active_count != want.active_count)
                $display("%0t: active_count expected %0d actual %0d", $time,
                         want.active_count, got.active_count);
            if (got.next_remaining_ms != want.next_remaining_ms)
                $display("%0t: next_remaining_ms expected %0d actual %0d", $time,
                         want.next_remaining_ms, got.next_remaining_ms);
            if (got.has_next != want.has_next)
                $display("%0t: has_next expected %0d actual %0d", $time, want.has_next,
                         got.has_next);
            if (got.last != want.last)
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            if (got != want) errors++;
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_axis_tvalid;
    logic                          o_s_axis_tready;
    logic [smtq_pkg::IN_BITS-1:0]  i_s_axis_tdata;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready;
    logic [smtq_pkg::OUT_BITS-1:0] o_m_axis_tdata;
    logic                          o_m_axis_tlast;

    timer_queue_scoreboard sb;
    bit                    stim_done;
    bit                    hold_off;

    sorted_multi_timer_queue_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic send_word(logic [1:0] op, logic [31:0] elapsed, logic [31:0] delay,
                             logic [3:0] tslot);
        int gap;
        gap = $urandom_range(0, 13);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {2'b00, tslot, delay, elapsed, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(op, elapsed, delay, tslot);
    endtask

    task automatic send_random();
        int r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(1, 40);
            2: v = $urandom_range(0, 2) == 0 ? 32'hFFFFFFFF : 32'd0;
            default: v = $urandom_range(1, 400);
        endcase
        if (r < 45)
            send_word(smtq_pkg::OP_INSTALL, $urandom, v, 4'($urandom));
        else if (r < 75)
            send_word(smtq_pkg::OP_TICK, v == 32'hFFFFFFFF && $urandom_range(0, 3) != 0 ?
                      $urandom_range(0, 60) : v, $urandom, 4'($urandom));
        else if (r < 97)
            send_word(smtq_pkg::OP_KILL, $urandom, $urandom, 4'($urandom));
        else
            send_word(OP_RESERVED, $urandom, $urandom, 4'($urandom));
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        stim_done = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_word(smtq_pkg::OP_TICK, 32'd0, 32'd0, 4'd0);
        send_word(smtq_pkg::OP_INSTALL, 32'd0, 32'd0, 4'd0);
        send_word(smtq_pkg::OP_KILL, 32'd0, 32'd0, 4'd3);
        send_word(smtq_pkg::OP_INSTALL, 32'd0, 32'hFFFFFFFF, 4'd0);
        send_word(smtq_pkg::OP_INSTALL, 32'd0, 32'd5, 4'd0);
        send_word(smtq_pkg::OP_INSTALL, 32'd0, 32'd5, 4'd0);
        send_word(smtq_pkg::OP_INSTALL, 32'd0, 32'd1, 4'd0);
        send_word(smtq_pkg::OP_KILL, 32'd0, 32'd0, 4'd1);
        send_word(OP_RESERVED, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF);
        for (int i = 0; i < 14; i++)
            send_word(smtq_pkg::OP_INSTALL, 32'd0, 32'd10 + 32'(i), 4'd0);
        send_word(smtq_pkg::OP_INSTALL, 32'd0, 32'd7, 4'd0);
        send_word(smtq_pkg::OP_KILL, 32'd0, 32'd0, 4'hF);
        send_word(smtq_pkg::OP_TICK, 32'd5, 32'd0, 4'd0);
        send_word(smtq_pkg::OP_TICK, 32'hFFFFFFFF, 32'd0, 4'd0);
        for (int i = 0; i < 260; i++) send_random();
        for (int i = 0; i < 16; i++) send_word(smtq_pkg::OP_INSTALL, 32'd0, 32'd3, 4'd0);
        send_word(smtq_pkg::OP_TICK, 32'd3, 32'd0, 4'd0);
        i_s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        int wait_left;
        i_m_axis_tready = 1'b0;
        hold_off = 0;
        wait_left = $urandom_range(0, 13);
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_word(t_timer_word'({o_m_axis_tdata[2:0], o_m_axis_tdata[6:3],
                                             o_m_axis_tdata[11:7], o_m_axis_tdata[43:12],
                                             o_m_axis_tdata[44], o_m_axis_tlast}));
                wait_left = $urandom_range(0, 13);
            end
            if (hold_off) begin
                i_m_axis_tready <= 1'b0;
            end else if (wait_left != 0) begin
                i_m_axis_tready <= 1'b0;
                wait_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int held;
        repeat (400) @(posedge i_clk);
        hold_off = 1;
        held = 0;
        while (held < 600) begin
            @(posedge i_clk);
            held++;
        end
        hold_off = 0;
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
